>>> hdl/cfpc_pkg.sv
// shared types and codes of the contact force pair cache
package cfpc_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [1:0] KIND_BODY_PAIR   = 2'd0;
   localparam logic [1:0] KIND_KINEMATIC   = 2'd1;
   localparam logic [1:0] KIND_PLANE_BODY  = 2'd2;
   localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

   localparam logic [2:0] STATUS_OK    = 3'd0;
   localparam logic [2:0] STATUS_DUP   = 3'd1;
   localparam logic [2:0] STATUS_ORDER = 3'd2;
   localparam logic [2:0] STATUS_FULL  = 3'd3;
   localparam logic [2:0] STATUS_KIND  = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  kind;
      logic [15:0] index_a;
      logic [15:0] index_b;
      logic [63:0] force_word_0;
      logic [63:0] force_word_1;
   } req_word_type;

   typedef struct packed {
      logic        found;
      logic [63:0] out_force_0;
      logic [63:0] out_force_1;
      logic        all_empty;
      logic [2:0]  status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_CMP,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_PRE,
      FIN_HIT,
      FIN_MISS
   } fin_type;

   typedef struct packed {
      logic    load;
      logic    clear;
      logic    scan_start;
      logic    rd_issue;
      logic    idx_inc;
      fin_type fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic keyed;
      logic is_clear;
      logic cnt_zero;
      logic last;
      logic hit;
   } dp_status_type;

endpackage

>>> hdl/cfpc_if.sv
// valid/ready channel interfaces for request and response words
interface cfpc_req_if;
   logic                 valid;
   logic                 ready;
   cfpc_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface cfpc_rsp_if;
   logic                 valid;
   logic                 ready;
   cfpc_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hdl/cfpc_ctrl.sv
// sequencer for decode, table scan, store and response
module cfpc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  cfpc_pkg::dp_status_type stat,
   output cfpc_pkg::ctrl_cmd_type  ctrl
);

   cfpc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfpc_pkg::ST_IDLE: begin
            if (req_valid) state_in = cfpc_pkg::ST_START;
         end
         cfpc_pkg::ST_START: begin
            if (!stat.keyed || stat.cnt_zero) state_in = cfpc_pkg::ST_RESP;
            else state_in = cfpc_pkg::ST_READ;
         end
         cfpc_pkg::ST_READ: state_in = cfpc_pkg::ST_CMP;
         cfpc_pkg::ST_CMP: begin
            if (stat.hit || stat.last) state_in = cfpc_pkg::ST_RESP;
            else state_in = cfpc_pkg::ST_READ;
         end
         cfpc_pkg::ST_RESP: begin
            if (rsp_ready) state_in = cfpc_pkg::ST_IDLE;
         end
         default: state_in = cfpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.fin = cfpc_pkg::FIN_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         cfpc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         cfpc_pkg::ST_START: begin
            if (!stat.keyed) begin
               ctrl.fin   = cfpc_pkg::FIN_PRE;
               ctrl.clear = stat.is_clear;
            end else if (stat.cnt_zero) begin
               ctrl.fin = cfpc_pkg::FIN_MISS;
            end else begin
               ctrl.scan_start = 1'b1;
            end
         end
         cfpc_pkg::ST_READ: ctrl.rd_issue = 1'b1;
         cfpc_pkg::ST_CMP: begin
            if (stat.hit) ctrl.fin = cfpc_pkg::FIN_HIT;
            else if (stat.last) ctrl.fin = cfpc_pkg::FIN_MISS;
            else ctrl.idx_inc = 1'b1;
         end
         cfpc_pkg::ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

>>> hdl/cfpc_datapath.sv
// key build, table memories, scan pointer, fill counts and response register
module cfpc_datapath #(
   parameter int TABLE_ENTRIES    = 256,
   parameter int BODY_INDEX_BITS  = 16,
   parameter int FORCE_COMPONENTS = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfpc_pkg::req_word_type  req_data,
   input  cfpc_pkg::ctrl_cmd_type  ctrl,
   output cfpc_pkg::dp_status_type stat,
   output cfpc_pkg::rsp_word_type  rsp_data
);

   localparam int IDX_W = (BODY_INDEX_BITS < 16) ? BODY_INDEX_BITS : 16;
   localparam int KEY_W = 2 * IDX_W;
   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int CW    = $clog2(TABLE_ENTRIES + 1);

   cfpc_pkg::req_word_type req_ff;

   logic [KEY_W-1:0] pair_key_mem [TABLE_ENTRIES];
   logic [63:0]      pair_f0_mem  [TABLE_ENTRIES];
   logic [63:0]      pair_f1_mem  [TABLE_ENTRIES];
   logic [KEY_W-1:0] plane_key_mem [TABLE_ENTRIES];
   logic [63:0]      plane_f0_mem  [TABLE_ENTRIES];
   logic [63:0]      plane_f1_mem  [TABLE_ENTRIES];

   logic [KEY_W-1:0] pair_key_rd_ff, plane_key_rd_ff;
   logic [63:0]      pair_f0_rd_ff, pair_f1_rd_ff, plane_f0_rd_ff, plane_f1_rd_ff;

   logic [AW-1:0] idx_ff;
   logic [CW-1:0] pair_cnt_ff, plane_cnt_ff;
   logic          found_ff;
   logic [63:0]   f0_ff, f1_ff;
   logic [2:0]    status_ff;

   logic [IDX_W-1:0] a_m, b_m, lo_m, hi_m;
   logic             a_lt_b, keyed, use_plane, is_insert;
   logic [2:0]       pre_status;
   logic [KEY_W-1:0] key, rd_key;
   logic [CW-1:0]    cnt_sel;
   logic             full, do_store;
   logic [63:0]      f1_in_word;

   assign a_m    = req_ff.index_a[IDX_W-1:0];
   assign b_m    = req_ff.index_b[IDX_W-1:0];
   assign a_lt_b = a_m < b_m;
   assign lo_m   = a_lt_b ? a_m : b_m;
   assign hi_m   = a_lt_b ? b_m : a_m;
   assign is_insert = req_ff.cmd == cfpc_pkg::CMD_INSERT;

   always_comb begin
      keyed      = 1'b0;
      use_plane  = 1'b0;
      key        = {a_m, b_m};
      pre_status = cfpc_pkg::STATUS_OK;
      if (req_ff.cmd == cfpc_pkg::CMD_INSERT || req_ff.cmd == cfpc_pkg::CMD_LOOKUP) begin
         unique case (req_ff.kind)
            cfpc_pkg::KIND_BODY_PAIR: begin
               keyed = a_lt_b;
               if (!a_lt_b) pre_status = cfpc_pkg::STATUS_ORDER;
            end
            cfpc_pkg::KIND_KINEMATIC: begin
               key   = {lo_m, hi_m};
               keyed = lo_m != hi_m;
               if (lo_m == hi_m) pre_status = cfpc_pkg::STATUS_ORDER;
            end
            cfpc_pkg::KIND_PLANE_BODY: begin
               use_plane = 1'b1;
               keyed     = 1'b1;
            end
            default: pre_status = cfpc_pkg::STATUS_KIND;
         endcase
      end
   end

   assign cnt_sel  = use_plane ? plane_cnt_ff : pair_cnt_ff;
   assign full     = cnt_sel == CW'(TABLE_ENTRIES);
   assign rd_key   = use_plane ? plane_key_rd_ff : pair_key_rd_ff;
   assign do_store = (ctrl.fin == cfpc_pkg::FIN_MISS) && is_insert && !full;
   assign f1_in_word = (FORCE_COMPONENTS >= 2) ? req_ff.force_word_1 : 64'd0;

   assign stat.keyed    = keyed;
   assign stat.is_clear = req_ff.cmd == cfpc_pkg::CMD_CLEAR;
   assign stat.cnt_zero = cnt_sel == '0;
   assign stat.last     = (CW'(idx_ff) + CW'(1)) == cnt_sel;
   assign stat.hit      = rd_key == key;

   always_ff @(posedge clock) begin
      if (ctrl.load) req_ff <= req_data;
   end

   // tables fill in slot order, so the fill count is the next free slot
   always_ff @(posedge clock) begin
      if (do_store && !use_plane) begin
         pair_key_mem[pair_cnt_ff[AW-1:0]] <= key;
         pair_f0_mem[pair_cnt_ff[AW-1:0]]  <= req_ff.force_word_0;
         pair_f1_mem[pair_cnt_ff[AW-1:0]]  <= f1_in_word;
      end
      if (ctrl.rd_issue) begin
         pair_key_rd_ff <= pair_key_mem[idx_ff];
         pair_f0_rd_ff  <= pair_f0_mem[idx_ff];
         pair_f1_rd_ff  <= pair_f1_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (do_store && use_plane) begin
         plane_key_mem[plane_cnt_ff[AW-1:0]] <= key;
         plane_f0_mem[plane_cnt_ff[AW-1:0]]  <= req_ff.force_word_0;
         plane_f1_mem[plane_cnt_ff[AW-1:0]]  <= f1_in_word;
      end
      if (ctrl.rd_issue) begin
         plane_key_rd_ff <= plane_key_mem[idx_ff];
         plane_f0_rd_ff  <= plane_f0_mem[idx_ff];
         plane_f1_rd_ff  <= plane_f1_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_start) idx_ff <= '0;
      else if (ctrl.idx_inc) idx_ff <= idx_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         pair_cnt_ff  <= '0;
         plane_cnt_ff <= '0;
      end else if (do_store) begin
         if (use_plane) plane_cnt_ff <= plane_cnt_ff + CW'(1);
         else pair_cnt_ff <= pair_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.fin)
         cfpc_pkg::FIN_PRE: begin
            found_ff  <= 1'b0;
            f0_ff     <= '0;
            f1_ff     <= '0;
            status_ff <= pre_status;
         end
         cfpc_pkg::FIN_HIT: begin
            found_ff  <= !is_insert;
            f0_ff     <= is_insert ? 64'd0 : (use_plane ? plane_f0_rd_ff : pair_f0_rd_ff);
            f1_ff     <= (is_insert || FORCE_COMPONENTS < 2) ? 64'd0 :
                         (use_plane ? plane_f1_rd_ff : pair_f1_rd_ff);
            status_ff <= is_insert ? cfpc_pkg::STATUS_DUP : cfpc_pkg::STATUS_OK;
         end
         cfpc_pkg::FIN_MISS: begin
            found_ff  <= 1'b0;
            f0_ff     <= '0;
            f1_ff     <= '0;
            status_ff <= (is_insert && full) ? cfpc_pkg::STATUS_FULL : cfpc_pkg::STATUS_OK;
         end
         default: ;
      endcase
   end

   assign rsp_data.found       = found_ff;
   assign rsp_data.out_force_0 = f0_ff;
   assign rsp_data.out_force_1 = f1_ff;
   assign rsp_data.all_empty   = (pair_cnt_ff == '0) && (plane_cnt_ff == '0);
   assign rsp_data.status      = status_ff;

endmodule

>>> hdl/contact_force_pair_cache_core.sv
// Contact force pair cache: two append-only tables (body pairs, plane-body) of
// TABLE_ENTRIES slots holding a key and a force vector each, searched linearly
// through one registered memory read per step. One word is handled at a time:
// a word is accepted in IDLE and decoded in START, and the next word is accepted
// only after the response is taken. A word that needs no search (clear, bad
// order, unsupported kind, or a table with no entries) goes straight to RESP.
// An insert or lookup that scans steps through READ then CMP for each occupied
// slot of the addressed table until a hit or the last entry, then goes to RESP.
// Clear only resets the fill counts, so no clearing pass is needed after reset.
module contact_force_pair_cache_core #(
   parameter int TABLE_ENTRIES    = 256,
   parameter int BODY_INDEX_BITS  = 16,
   parameter int FORCE_COMPONENTS = 2
) (
   input logic     clock,
   input logic     reset,
   cfpc_req_if.sink   req_chan,
   cfpc_rsp_if.source rsp_chan
);

   cfpc_pkg::ctrl_cmd_type  ctrl;
   cfpc_pkg::dp_status_type stat;

   cfpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   cfpc_datapath #(
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .BODY_INDEX_BITS  (BODY_INDEX_BITS),
      .FORCE_COMPONENTS (FORCE_COMPONENTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_chan.data),
      .ctrl     (ctrl),
      .stat     (stat),
      .rsp_data (rsp_chan.data)
   );

endmodule

>>> hdl/cfpc_checker.sv
// port-level checks of the cache core and their bind
module cfpc_core_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       found,
   input logic [63:0] out_force_0,
   input logic [63:0] out_force_1,
   input logic [2:0] status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(found))
      else $error("response word dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("word accepted while a response is pending");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> out_force_0 == 64'd0 && out_force_1 == 64'd0)
      else $error("forces nonzero without a hit");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found |-> status == cfpc_pkg::STATUS_OK)
      else $error("hit reported with error status");

endmodule

bind contact_force_pair_cache_core cfpc_core_props u_cfpc_core_props (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .found       (rsp_chan.data.found),
   .out_force_0 (rsp_chan.data.out_force_0),
   .out_force_1 (rsp_chan.data.out_force_1),
   .status      (rsp_chan.data.status)
);

>>> dv/cfpc_checker.sv
// checker for the contact force pair cache: watches both channels, predicts and compares
module cfpc_checker #(
   parameter int TABLE_ENTRIES = 256
) (
   input logic   clock,
   input logic   reset,
   cfpc_req_if   req_mon,
   cfpc_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow tables, searched by key
   logic [63:0] pair_force_lo [logic [31:0]];
   logic [63:0] pair_force_hi [logic [31:0]];
   logic [63:0] plane_force_lo [logic [31:0]];
   logic [63:0] plane_force_hi [logic [31:0]];

   cfpc_pkg::rsp_word_type expected_rsp_q[$];

   assign pending_count = expected_rsp_q.size();

   function automatic cfpc_pkg::rsp_word_type cache_step(cfpc_pkg::req_word_type w);
      cfpc_pkg::rsp_word_type r;
      logic [31:0] key;
      logic [15:0] lo_i, hi_i;
      logic keyed, plane;
      r = '0;
      r.status = cfpc_pkg::STATUS_OK;
      keyed = 1'b0;
      plane = 1'b0;
      key = '0;
      if (w.cmd == cfpc_pkg::CMD_CLEAR) begin
         pair_force_lo.delete();
         pair_force_hi.delete();
         plane_force_lo.delete();
         plane_force_hi.delete();
      end else if (w.cmd == cfpc_pkg::CMD_INSERT || w.cmd == cfpc_pkg::CMD_LOOKUP) begin
         if (w.kind == cfpc_pkg::KIND_BODY_PAIR) begin
            if (w.index_a < w.index_b) begin
               key = {w.index_a, w.index_b};
               keyed = 1'b1;
            end else r.status = cfpc_pkg::STATUS_ORDER;
         end else if (w.kind == cfpc_pkg::KIND_KINEMATIC) begin
            lo_i = (w.index_a < w.index_b) ? w.index_a : w.index_b;
            hi_i = (w.index_a < w.index_b) ? w.index_b : w.index_a;
            if (lo_i != hi_i) begin
               key = {lo_i, hi_i};
               keyed = 1'b1;
            end else r.status = cfpc_pkg::STATUS_ORDER;
         end else if (w.kind == cfpc_pkg::KIND_PLANE_BODY) begin
            key = {w.index_a, w.index_b};
            keyed = 1'b1;
            plane = 1'b1;
         end else r.status = cfpc_pkg::STATUS_KIND;
         if (keyed && plane) begin
            if (w.cmd == cfpc_pkg::CMD_INSERT) begin
               if (plane_force_lo.exists(key)) r.status = cfpc_pkg::STATUS_DUP;
               else if (plane_force_lo.size() >= TABLE_ENTRIES)
                  r.status = cfpc_pkg::STATUS_FULL;
               else begin
                  plane_force_lo[key] = w.force_word_0;
                  plane_force_hi[key] = w.force_word_1;
               end
            end else if (plane_force_lo.exists(key)) begin
               r.found = 1'b1;
               r.out_force_0 = plane_force_lo[key];
               r.out_force_1 = plane_force_hi[key];
            end
         end else if (keyed) begin
            if (w.cmd == cfpc_pkg::CMD_INSERT) begin
               if (pair_force_lo.exists(key)) r.status = cfpc_pkg::STATUS_DUP;
               else if (pair_force_lo.size() >= TABLE_ENTRIES)
                  r.status = cfpc_pkg::STATUS_FULL;
               else begin
                  pair_force_lo[key] = w.force_word_0;
                  pair_force_hi[key] = w.force_word_1;
               end
            end else if (pair_force_lo.exists(key)) begin
               r.found = 1'b1;
               r.out_force_0 = pair_force_lo[key];
               r.out_force_1 = pair_force_hi[key];
            end
         end
      end
      r.all_empty = (pair_force_lo.size() == 0 && plane_force_lo.size() == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      cfpc_pkg::rsp_word_type e, g;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_rsp_q.push_back(cache_step(req_mon.data));
         if (rsp_mon.valid && rsp_mon.ready) begin
            g = rsp_mon.data;
            if (expected_rsp_q.size() == 0) report_mismatch("unexpected word", 64'd0, 64'd0);
            else begin
               e = expected_rsp_q.pop_front();
               if (g.found !== e.found)
                  report_mismatch("found", 64'(g.found), 64'(e.found));
               if (g.out_force_0 !== e.out_force_0)
                  report_mismatch("out_force_0", g.out_force_0, e.out_force_0);
               if (g.out_force_1 !== e.out_force_1)
                  report_mismatch("out_force_1", g.out_force_1, e.out_force_1);
               if (g.all_empty !== e.all_empty)
                  report_mismatch("all_empty", 64'(g.all_empty), 64'(e.all_empty));
               if (g.status !== e.status)
                  report_mismatch("status", 64'(g.status), 64'(e.status));
            end
         end
      end
   end
endmodule

>>> dv/tb_contact_force_pair_cache_core.sv
// testbench top: drives request words, stalls responses, gives the verdict
module tb_contact_force_pair_cache_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   logic hold_off = 1'b0;
   logic no_idle = 1'b0;

   cfpc_req_if req_chan();
   cfpc_rsp_if rsp_chan();

   contact_force_pair_cache_core i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   cfpc_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // small index pool so lookups and duplicates hit often
   logic [15:0] idx_pool[8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd100,
                               16'hfffe, 16'hffff};

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [15:0] rand_index();
      if ($urandom_range(0, 3) != 0) return idx_pool[3'($urandom_range(0, 7))];
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_word(logic [1:0] cmd, logic [1:0] kind, logic [15:0] a,
                            logic [15:0] b, logic [63:0] f0, logic [63:0] f1);
      int gap;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= '{cmd: cmd, kind: kind, index_a: a, index_b: b,
                         force_word_0: f0, force_word_1: f1};
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic random_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) send_word(cfpc_pkg::CMD_CLEAR, 2'($urandom_range(0, 3)), rand_index(),
                           rand_index(), rand64(), rand64());
      else if (r < 4) send_word(cfpc_pkg::CMD_NONE, 2'($urandom_range(0, 3)), rand_index(),
                                rand_index(), rand64(), rand64());
      else send_word(2'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_index(),
                     rand_index(), rand64(), rand64());
   endtask

   // response side stall process
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: every op, orders, kinds, duplicates, field extremes
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_BODY_PAIR, 16'd1, 16'd2, '0, '0);
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_BODY_PAIR, 16'd0, 16'hffff, '1, '1);
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_BODY_PAIR, 16'd0, 16'hffff, '0, '0);
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_BODY_PAIR, 16'd0, 16'hffff, '0, '0);
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_BODY_PAIR, 16'd5, 16'd5,
                rand64(), rand64());
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_BODY_PAIR, 16'd9, 16'd5,
                rand64(), rand64());
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_BODY_PAIR, 16'hffff, 16'd0, '0, '0);
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_KINEMATIC, 16'd7, 16'd3,
                rand64(), rand64());
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_KINEMATIC, 16'd3, 16'd7, '0, '0);
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_KINEMATIC, 16'd3, 16'd7,
                rand64(), rand64());
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_KINEMATIC, 16'd4, 16'd4,
                rand64(), rand64());
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_PLANE_BODY, 16'hffff, 16'hffff,
                64'h5555, '1);
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_PLANE_BODY, 16'd2, 16'd1,
                rand64(), rand64());
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_PLANE_BODY, 16'hffff, 16'hffff,
                '0, '0);
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_PLANE_BODY, 16'd1, 16'd2, '0, '0);
      send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_UNSUPPORTED, 16'd1, 16'd2,
                rand64(), rand64());
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_UNSUPPORTED, 16'd1, 16'd2, '0, '0);
      send_word(cfpc_pkg::CMD_NONE, cfpc_pkg::KIND_BODY_PAIR, 16'd1, 16'd2, '1, '1);
      send_word(cfpc_pkg::CMD_CLEAR, cfpc_pkg::KIND_UNSUPPORTED, '1, '1, '1, '1);
      send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_BODY_PAIR, 16'd0, 16'hffff, '0, '0);
      // fill the pair table to overflow, then probe
      for (int i = 0; i < 258; i++)
         send_word(cfpc_pkg::CMD_INSERT, cfpc_pkg::KIND_BODY_PAIR, 16'd0, 16'(i + 1),
                   rand64(), rand64());
      for (int i = 0; i < 20; i++)
         send_word(cfpc_pkg::CMD_LOOKUP, cfpc_pkg::KIND_BODY_PAIR, 16'd0,
                   16'($urandom_range(1, 258)), '0, '0);
      send_word(cfpc_pkg::CMD_CLEAR, cfpc_pkg::KIND_BODY_PAIR, '0, '0, '0, '0);
      // long receiver hold-off while words keep coming
      hold_off = 1'b1;
      for (int i = 0; i < 30; i++) random_word();
      // sender pause until drained
      req_chan.valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
      for (int i = 0; i < 600; i++) random_word();
      no_idle = 1'b1;
      for (int i = 0; i < 100; i++) random_word();
      req_chan.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (600) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
